// File: sv/rpm_pkg.sv
// Shared types and fixed widths of the multichannel RMS and peak meter.
// Used by the interfaces, the divide/root unit and the top level.
package rpm_pkg;

	localparam int NUM_CH   = 4;
	localparam int SAMPLE_W = 16;
	localparam int ROOT_W   = 16;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int FRAMES_W = 12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_ROOT,
		ST_OUT
	} meter_state_t;

	typedef enum logic [1:0] {
		DR_IDLE,
		DR_DIV,
		DR_ROOT
	} dr_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dr_stat_t;

endpackage

// File: sv/rpm_frame_if.sv
// Frame channel: four TDM samples and the window end mark, valid/ready.
// Depends on rpm_pkg for the sample width.
interface rpm_frame_if import rpm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_ch0;
	logic signed [SAMPLE_W-1:0] sample_ch1;
	logic signed [SAMPLE_W-1:0] sample_ch2;
	logic signed [SAMPLE_W-1:0] sample_ch3;
	logic                       window_end;

	modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		window_end, input ready);
	modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		window_end, output ready);
endinterface

// File: sv/rpm_result_if.sv
// Result channel: per-channel RMS and peak, frame count and overflow flag.
// Depends on rpm_pkg for the field widths.
interface rpm_result_if import rpm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ROOT_W-1:0]   rms_ch0;
	logic [ROOT_W-1:0]   rms_ch1;
	logic [ROOT_W-1:0]   rms_ch2;
	logic [ROOT_W-1:0]   rms_ch3;
	logic [SAMPLE_W-1:0] peak_ch0;
	logic [SAMPLE_W-1:0] peak_ch1;
	logic [SAMPLE_W-1:0] peak_ch2;
	logic [SAMPLE_W-1:0] peak_ch3;
	logic [FRAMES_W-1:0] frames_counted;
	logic                window_overflow;

	modport source (output valid, rms_ch0, rms_ch1, rms_ch2, rms_ch3, peak_ch0, peak_ch1,
		peak_ch2, peak_ch3, frames_counted, window_overflow, input ready);
	modport sink (input valid, rms_ch0, rms_ch1, rms_ch2, rms_ch3, peak_ch0, peak_ch1,
		peak_ch2, peak_ch3, frames_counted, window_overflow, output ready);
endinterface

// File: sv/multichannel_rms_peak_meter_unit.sv
// Top level of the four-channel RMS and peak level meter.
// Depends on rpm_pkg, rpm_frame_if, rpm_result_if and rpm_divroot.
//
// Usage:
//   frame  - sink channel, one TDM frame per item: four signed samples and
//            window_end marking the last frame of a measurement window.
//   result - source channel, one item per window: floor RMS and peak per
//            channel, frames counted and the overflow flag.
// Each accepted frame occupies the block for its accept cycle and five
// steps of the shared 16x16 squarer and accumulator, one channel a step;
// ready is low meanwhile. A frame arriving with MAX_FRAMES already counted
// is dropped in its accept cycle and sets the overflow flag.
// On a window end the shared divide/root unit runs per channel on the
// SUM_W-bit sums, SUM_W = 32 + clog2(MAX_FRAMES + 1); after the last channel
// the result is loaded into the output register as soon as that is free,
// then the window state clears and frames are taken again.
// The result sits in an output register: frames keep being accepted while
// the receiver stalls, and only the next window end waits for it.
// Reset clears all sums, peaks, the count and the overflow flag and
// drops any pending result.
module multichannel_rms_peak_meter_unit import rpm_pkg::*; #(
	parameter int MAX_FRAMES = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	rpm_frame_if.sink     frame,
	rpm_result_if.source  result
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W = 2 * SAMPLE_W + CNT_W;
	localparam logic [2:0] STEP_LAST = 3'(NUM_CH);

	meter_state_t      st_q, st_d;
	logic [2:0]        step_q;
	logic [1:0]        ch_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [SUM_W-1:0]  sum_q  [NUM_CH];
	logic [SAMPLE_W-1:0] peak_q [NUM_CH];
	logic [SAMPLE_W-1:0] samp_q [NUM_CH];
	logic              wend_q;
	logic [2*SAMPLE_W-1:0] sq_q;
	logic [ROOT_W-1:0] rms_q [NUM_CH];
	logic              res_valid_q;

	logic              full;
	logic              accept;
	logic              dr_start;
	logic              load_out;
	logic [SAMPLE_W-1:0] samp;
	logic [SAMPLE_W-1:0] mag;
	logic [1:0]        idx;
	logic [1:0]        prev;
	dr_stat_t          dr_stat;
	logic [ROOT_W-1:0] dr_root;

	assign full   = (count_q >= CNT_W'(MAX_FRAMES));
	assign accept = frame.valid && frame.ready;
	assign idx    = step_q[1:0];
	assign prev   = 2'(step_q - 3'd1);
	assign samp   = samp_q[idx];
	assign mag    = samp[SAMPLE_W-1] ? (~samp + 1'b1) : samp;

	always_comb begin
		st_d        = st_q;
		frame.ready = 1'b0;
		dr_start    = 1'b0;
		load_out    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					if (!full) st_d = ST_ACC;
					else if (frame.window_end) st_d = ST_ROOT;
				end
			end
			ST_ACC: begin
				if (step_q == STEP_LAST) st_d = wend_q ? ST_ROOT : ST_IDLE;
			end
			ST_ROOT: begin
				dr_start = !dr_stat.busy && !dr_stat.done;
				if (dr_stat.done && ch_q == 2'(NUM_CH - 1)) st_d = ST_OUT;
			end
			ST_OUT: begin
				load_out = !res_valid_q || result.ready;
				if (load_out) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= '0;
			ch_q        <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				sum_q[i]  <= '0;
				peak_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (load_out) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						ch_q   <= '0;
						if (full) ovf_q <= 1'b1;
					end
				end
				ST_ACC: begin
					step_q <= step_q + 1'b1;
					if (step_q < STEP_LAST && mag > peak_q[idx]) peak_q[idx] <= mag;
					if (step_q != '0) sum_q[prev] <= sum_q[prev] + SUM_W'(sq_q);
					if (step_q == STEP_LAST) count_q <= count_q + 1'b1;
				end
				ST_ROOT: begin
					if (dr_stat.done) ch_q <= ch_q + 1'b1;
				end
				ST_OUT: begin
					if (load_out) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						for (int i = 0; i < NUM_CH; i++) begin
							sum_q[i]  <= '0;
							peak_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q[0] <= frame.sample_ch0;
			samp_q[1] <= frame.sample_ch1;
			samp_q[2] <= frame.sample_ch2;
			samp_q[3] <= frame.sample_ch3;
			wend_q    <= frame.window_end;
		end
		if (st_q == ST_ACC && step_q < STEP_LAST)
			sq_q <= (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
		if (st_q == ST_ROOT && dr_stat.done) rms_q[ch_q] <= dr_root;
		if (load_out) begin
			result.rms_ch0         <= rms_q[0];
			result.rms_ch1         <= rms_q[1];
			result.rms_ch2         <= rms_q[2];
			result.rms_ch3         <= rms_q[3];
			result.peak_ch0        <= peak_q[0];
			result.peak_ch1        <= peak_q[1];
			result.peak_ch2        <= peak_q[2];
			result.peak_ch3        <= peak_q[3];
			result.frames_counted  <= FRAMES_W'(count_q);
			result.window_overflow <= ovf_q;
		end
	end

	assign result.valid = res_valid_q;

	rpm_divroot #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_divroot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dr_start),
		.dividend (sum_q[ch_q]),
		.divisor  (count_q),
		.stat     (dr_stat),
		.root     (dr_root)
	);

endmodule

// File: sv/rpm_divroot.sv
// Iterative unit: restoring divide of a square sum by the frame count, then
// digit-by-digit integer square root of the quotient, on one shared subtractor.
// Depends on rpm_pkg.
module rpm_divroot import rpm_pkg::*; #(
	parameter int SUM_W = 44,
	parameter int CNT_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output dr_stat_t          stat,
	output logic [ROOT_W-1:0] root
);

	localparam int IT_W  = $clog2(SUM_W);
	localparam int SUB_W = (CNT_W + 1 > ROOT_W + 4) ? CNT_W + 1 : ROOT_W + 4;

	dr_state_t         st_q, st_d;
	logic [SUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  den_q;
	logic [SUB_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [IT_W-1:0]   it_q;
	logic              done_q;

	logic [SUB_W-1:0]  opa, opb;
	logic [SUB_W:0]    diff;
	logic              borrow;

	always_comb begin
		case (st_q)
			DR_DIV: begin
				opa = SUB_W'({rem_q[CNT_W-1:0], num_q[SUM_W-1]});
				opb = SUB_W'(den_q);
			end
			DR_ROOT: begin
				opa = {rem_q[SUB_W-3:0], num_q[RAD_W-1 -: 2]};
				opb = SUB_W'({root_q, 2'b01});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		diff   = {1'b0, opa} - {1'b0, opb};
		borrow = diff[SUB_W];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			DR_IDLE: if (start) st_d = DR_DIV;
			DR_DIV:  if (it_q == '0) st_d = DR_ROOT;
			DR_ROOT: if (it_q == '0) st_d = DR_IDLE;
			default: st_d = DR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DR_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DR_ROOT) && (it_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DR_IDLE: begin
				if (start) begin
					num_q <= dividend;
					den_q <= divisor;
					rem_q <= '0;
					it_q  <= IT_W'(SUM_W - 1);
				end
			end
			DR_DIV: begin
				num_q <= {num_q[SUM_W-2:0], ~borrow};
				if (it_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					it_q   <= IT_W'(ROOT_W - 1);
				end else begin
					rem_q <= borrow ? opa : diff[SUB_W-1:0];
					it_q  <= it_q - 1'b1;
				end
			end
			DR_ROOT: begin
				num_q  <= num_q << 2;
				rem_q  <= borrow ? opa : diff[SUB_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], ~borrow};
				it_q   <= it_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.busy = (st_q != DR_IDLE);
	assign stat.done = done_q;
	assign root      = root_q;

endmodule
